/* hdl/periodic_task_scheduler_top_defines.svh */
// Assertion macros for the periodic task scheduler.
// Depends on nothing; included by the top level only.
`ifndef PERIODIC_TASK_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/psc_pkg.sv */
// Shared types, codes and constants of the periodic task scheduler.
// Used by psc_cell, psc_eval and periodic_task_scheduler_top.
package psc_pkg;

    localparam int SLOT_W       = 4;
    localparam int DATA_W       = 32;
    localparam int SLEEP_W      = 10;
    localparam int CMD_W        = 3;
    localparam int MAX_SCAN     = 16;
    localparam int NUM_SLOTS_DEF = 16;

    localparam logic [SLEEP_W-1:0] SLEEP_CAP = 10'd1000;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SLEEP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STATS  = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] interval;
        logic [DATA_W-1:0] last_time;
        logic [DATA_W-1:0] calls;
    } slot_rec_t;

    typedef struct packed {
        slot_rec_t          rec_next;
        logic               hit;
        logic [DATA_W-1:0]  hit_calls;
        logic [SLEEP_W-1:0] wait_next;
    } eval_t;

endpackage

/* hdl/psc_cell.sv */
// One slot cell of the scheduler ring: holds one task record.
// Depends on psc_pkg.
module psc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift,
    input  psc_pkg::slot_rec_t            rec_in,
    input  logic                          wr_add,
    input  logic                          wr_remove,
    input  logic [psc_pkg::DATA_W-1:0]    add_mask,
    input  logic [psc_pkg::DATA_W-1:0]    add_interval,
    output psc_pkg::slot_rec_t            rec
);

    logic                       valid_reg;
    logic [psc_pkg::DATA_W-1:0] mask_reg;
    logic [psc_pkg::DATA_W-1:0] interval_reg;
    logic [psc_pkg::DATA_W-1:0] last_time_reg;
    logic [psc_pkg::DATA_W-1:0] calls_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= rec_in.valid;
        end
        else if (wr_add)
        begin
            valid_reg <= 1'b1;
        end
        else if (wr_remove)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload: take the neighbor's record or load a new task
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            mask_reg      <= rec_in.mask;
            interval_reg  <= rec_in.interval;
            last_time_reg <= rec_in.last_time;
            calls_reg     <= rec_in.calls;
        end
        else if (wr_add)
        begin
            mask_reg      <= add_mask;
            interval_reg  <= add_interval;
            last_time_reg <= '0;
            calls_reg     <= '0;
        end
    end

    assign rec.valid     = valid_reg;
    assign rec.mask      = mask_reg;
    assign rec.interval  = interval_reg;
    assign rec.last_time = last_time_reg;
    assign rec.calls     = calls_reg;

endmodule

/* hdl/psc_eval.sv */
// Head-of-ring evaluator: judges the record at the ring head for one command.
// Depends on psc_pkg.
module psc_eval (
    input  logic [psc_pkg::CMD_W-1:0]   cmd,
    input  logic [psc_pkg::DATA_W-1:0]  now,
    input  logic [psc_pkg::DATA_W-1:0]  run_bits,
    input  logic [psc_pkg::SLEEP_W-1:0] min_wait,
    input  psc_pkg::slot_rec_t          rec,
    output psc_pkg::eval_t              ev
);

    logic                       eligible;
    logic [psc_pkg::DATA_W-1:0] elapsed;
    logic [psc_pkg::DATA_W-1:0] remain;

    assign eligible = rec.valid && ((rec.mask & run_bits) != '0);
    assign elapsed  = now - rec.last_time;
    assign remain   = rec.last_time + rec.interval - now;

    always_comb
    begin
        ev           = '0;
        ev.rec_next  = rec;
        ev.wait_next = min_wait;
        case (cmd)
            psc_pkg::CMD_TICK:
            begin
                if (eligible && (elapsed >= rec.interval))
                begin
                    ev.hit                = 1'b1;
                    ev.hit_calls          = rec.calls + 1'b1;
                    ev.rec_next.last_time = now;
                    ev.rec_next.calls     = rec.calls + 1'b1;
                end
            end
            psc_pkg::CMD_SLEEP:
            begin
                if (eligible)
                begin
                    if (rec.interval == psc_pkg::DATA_W'(1))
                    begin
                        ev.wait_next = '0;
                    end
                    else if (remain < psc_pkg::DATA_W'(min_wait))
                    begin
                        ev.wait_next = remain[psc_pkg::SLEEP_W-1:0];
                    end
                end
            end
            psc_pkg::CMD_STATS:
            begin
                if (rec.valid && (rec.calls != '0))
                begin
                    ev.hit            = 1'b1;
                    ev.hit_calls      = rec.calls;
                    ev.rec_next.calls = '0;
                end
            end
            default:
            begin
                ev.hit = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/periodic_task_scheduler_top.sv */
// Periodic task scheduler: top level with ring of slot cells and control.
// Depends on psc_pkg, psc_cell, psc_eval and periodic_task_scheduler_top_defines.svh.
//
// The task table sits in a ring of slot cells. Add and remove commands write
// their cell directly, leave busy low and give no result word. A tick, sleep
// query or stats read rotates the whole ring once past a single evaluator at
// the head, one slot per cycle, then passes through a flush state, and holds
// busy through both; the scan is capped at sixteen slots (slots beyond the
// sixteenth are never built). The last word is on the outputs in the same
// cycle that busy falls, and the next command can be taken in that same
// cycle; the rotation length sets the rate of scanning commands. Result
// words leave on result_valid, one cycle each, in ascending slot
// order; the last word of a command carries last. The receiver cannot stall
// the block, so the words must be taken as they come, and a scanning command
// always ends in at least one word. Write the run-state register only while
// busy is low and no result word is still due.
`include "periodic_task_scheduler_top_defines.svh"

module periodic_task_scheduler_top #(
    parameter int NUM_SLOTS = psc_pkg::NUM_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic [psc_pkg::CMD_W-1:0]      cmd,
    input  logic [psc_pkg::SLOT_W-1:0]     slot,
    input  logic [psc_pkg::DATA_W-1:0]     state_mask,
    input  logic [psc_pkg::DATA_W-1:0]     interval,
    input  logic [psc_pkg::DATA_W-1:0]     now,
    // run state register
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [psc_pkg::DATA_W-1:0]     cfg_data,
    // result words
    output logic                           result_valid,
    output logic [psc_pkg::SLOT_W-1:0]     task_slot,
    output logic                           fired,
    output logic [psc_pkg::SLEEP_W-1:0]    sleep_ms,
    output logic [psc_pkg::DATA_W-1:0]     call_count,
    output logic [psc_pkg::DATA_W-1:0]     sleep_total,
    output logic                           last
);

    localparam int SCAN  = (NUM_SLOTS < psc_pkg::MAX_SCAN) ? NUM_SLOTS : psc_pkg::MAX_SCAN;
    localparam int CNT_W = (SCAN > 1) ? $clog2(SCAN) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [psc_pkg::CMD_W-1:0]      cmd_reg;
    logic [psc_pkg::DATA_W-1:0]     now_reg;
    logic [psc_pkg::DATA_W-1:0]     run_bits_reg;
    logic [psc_pkg::DATA_W-1:0]     sleep_accum_reg, sleep_accum_next;
    logic [psc_pkg::DATA_W-1:0]     tot_reg;
    logic [psc_pkg::SLEEP_W-1:0]    min_reg;
    logic                           pend_valid_reg, pend_valid_next;
    logic [psc_pkg::SLOT_W-1:0]     pend_slot_reg;
    logic [psc_pkg::DATA_W-1:0]     pend_calls_reg;

    logic                           res_valid_reg, res_valid_next;
    logic [psc_pkg::SLOT_W-1:0]     task_slot_reg, task_slot_next;
    logic                           fired_reg, fired_next;
    logic [psc_pkg::SLEEP_W-1:0]    sleep_ms_reg, sleep_ms_next;
    logic [psc_pkg::DATA_W-1:0]     call_count_reg, call_count_next;
    logic [psc_pkg::DATA_W-1:0]     sleep_total_reg, sleep_total_next;
    logic                           last_reg, last_next;

    logic                           accept;
    logic                           scanning;
    logic                           scan_end;
    logic [psc_pkg::SLEEP_W-1:0]    final_wait;
    psc_pkg::slot_rec_t             cell_rec [SCAN];
    psc_pkg::slot_rec_t             cell_in  [SCAN];
    psc_pkg::eval_t                 ev;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign scanning  = (state_reg == ST_SCAN);
    assign scan_end  = (cnt_reg == CNT_W'(SCAN - 1));
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Ring of slot cells: advance one place per scan cycle, the head
    // record passes through the evaluator back into the tail.
    // ---------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < SCAN; gi++)
        begin : g_cell
            if (gi == SCAN - 1)
            begin : g_tail
                assign cell_in[gi] = ev.rec_next;
            end
            else
            begin : g_mid
                assign cell_in[gi] = cell_rec[gi+1];
            end

            psc_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .shift        (scanning),
                .rec_in       (cell_in[gi]),
                .wr_add       (accept && (cmd == psc_pkg::CMD_ADD) &&
                               (slot == psc_pkg::SLOT_W'(gi))),
                .wr_remove    (accept && (cmd == psc_pkg::CMD_REMOVE) &&
                               (slot == psc_pkg::SLOT_W'(gi))),
                .add_mask     (state_mask),
                .add_interval (interval),
                .rec          (cell_rec[gi])
            );
        end
    endgenerate

    psc_eval u_eval (
        .cmd       (cmd_reg),
        .now       (now_reg),
        .run_bits  (run_bits_reg),
        .min_wait  (min_reg),
        .rec       (cell_rec[0]),
        .ev        (ev)
    );

    // a stopped scheduler reports no wait at all
    assign final_wait = (run_bits_reg == '0) ? '0 : min_reg;

    // ---------------------------------------------------------------
    // Sequencer and result words. A hit is held back one place so the
    // final word of a command can be marked last.
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pend_valid_next  = pend_valid_reg;
        sleep_accum_next = sleep_accum_reg;
        res_valid_next   = 1'b0;
        task_slot_next   = '0;
        fired_next       = 1'b0;
        sleep_ms_next    = '0;
        call_count_next  = '0;
        sleep_total_next = '0;
        last_next        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && ((cmd == psc_pkg::CMD_TICK) ||
                               (cmd == psc_pkg::CMD_SLEEP) ||
                               (cmd == psc_pkg::CMD_STATS)))
                begin
                    state_next      = ST_SCAN;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (ev.hit)
                begin
                    pend_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_valid_next   = 1'b1;
                        task_slot_next   = pend_slot_reg;
                        fired_next       = (cmd_reg == psc_pkg::CMD_TICK);
                        call_count_next  = pend_calls_reg;
                        sleep_total_next = (cmd_reg == psc_pkg::CMD_STATS) ? tot_reg : '0;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (scan_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                res_valid_next = 1'b1;
                last_next      = 1'b1;
                state_next     = ST_IDLE;
                if (pend_valid_reg)
                begin
                    task_slot_next  = pend_slot_reg;
                    call_count_next = pend_calls_reg;
                end
                case (cmd_reg)
                    psc_pkg::CMD_TICK:
                    begin
                        fired_next = pend_valid_reg;
                    end
                    psc_pkg::CMD_SLEEP:
                    begin
                        sleep_ms_next    = final_wait;
                        sleep_accum_next = sleep_accum_reg +
                                           psc_pkg::DATA_W'(final_wait);
                    end
                    psc_pkg::CMD_STATS:
                    begin
                        sleep_total_next = tot_reg;
                        sleep_accum_next = '0;
                    end
                    default:
                    begin
                        res_valid_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
            run_bits_reg    <= '0;
            sleep_accum_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            pend_valid_reg  <= pend_valid_next;
            res_valid_reg   <= res_valid_next;
            sleep_accum_reg <= sleep_accum_next;
            if (cfg_valid && cfg_ready)
            begin
                run_bits_reg <= cfg_data;
            end
        end
    end

    // command payload, scan accumulators and result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            now_reg <= now;
            tot_reg <= sleep_accum_reg;
            min_reg <= psc_pkg::SLEEP_CAP;
        end
        else if (scanning)
        begin
            min_reg <= ev.wait_next;
        end
        if (scanning && ev.hit)
        begin
            pend_slot_reg  <= psc_pkg::SLOT_W'(cnt_reg);
            pend_calls_reg <= ev.hit_calls;
        end
        task_slot_reg   <= task_slot_next;
        fired_reg       <= fired_next;
        sleep_ms_reg    <= sleep_ms_next;
        call_count_reg  <= call_count_next;
        sleep_total_reg <= sleep_total_next;
        last_reg        <= last_next;
    end

    assign result_valid = res_valid_reg;
    assign task_slot    = task_slot_reg;
    assign fired        = fired_reg;
    assign sleep_ms     = sleep_ms_reg;
    assign call_count   = call_count_reg;
    assign sleep_total  = sleep_total_reg;
    assign last         = last_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `PSC_ASSERT_NEXT(a_no_word_after_accept, clk, rst_n, start && !busy, !result_valid,
        "result word right after a command was taken")
    `PSC_ASSERT_IMP(a_last_ends_command, clk, rst_n, result_valid && last, !busy,
        "last word seen while a scan is still running")
    `PSC_ASSERT_IMP(a_count_in_range, clk, rst_n, state_reg == ST_SCAN,
        cnt_reg <= CNT_W'(SCAN - 1), "scan position beyond the ring")
    `PSC_ASSERT_NEXT(a_flush_one_word, clk, rst_n, state_reg == ST_FLUSH,
        result_valid && last && (state_reg == ST_IDLE), "flush did not end the command")

endmodule

/* verif/periodic_task_scheduler_tb.sv */
// Self-checking testbench for periodic_task_scheduler_top: directed and random commands,
// predicted by a scoreboard class and checked word by word on the result strobe.
// Depends on psc_pkg and the scheduler RTL only.
`timescale 1ns / 100ps

module testbench;

    localparam int N_SLOTS     = psc_pkg::NUM_SLOTS_DEF;
    localparam int SCAN_N      = (N_SLOTS < psc_pkg::MAX_SCAN) ? N_SLOTS : psc_pkg::MAX_SCAN;
    localparam int CYCLE_LIMIT = 400000;
    // settle pause: long enough for a full ring rotation and its flush
    localparam int SETTLE_CYCLES = N_SLOTS + 8;
    localparam logic [psc_pkg::CMD_W-1:0] CMD_TOP = '1;
    localparam logic [psc_pkg::DATA_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [psc_pkg::SLOT_W-1:0]  slot_no;
        logic                        fired;
        logic [psc_pkg::SLEEP_W-1:0] sleep_ms;
        logic [psc_pkg::DATA_W-1:0]  calls;
        logic [psc_pkg::DATA_W-1:0]  total;
        logic                        last_word;
    } result_word_t;

    // Scoreboard: its own copy of the task table, predicts the result words
    // of each accepted command and checks the words that come out.
    class sched_scoreboard;
        logic [psc_pkg::DATA_W-1:0] run_bits;
        bit                         valid[N_SLOTS];
        logic [psc_pkg::DATA_W-1:0] mask[N_SLOTS];
        logic [psc_pkg::DATA_W-1:0] ivl[N_SLOTS];
        logic [psc_pkg::DATA_W-1:0] last_time[N_SLOTS];
        logic [psc_pkg::DATA_W-1:0] calls[N_SLOTS];
        logic [psc_pkg::DATA_W-1:0] sleep_sum;
        result_word_t               due_words[$];
        int                         errors;
        int                         words_seen;

        function new();
            run_bits = '0;
            sleep_sum = '0;
            errors = 0;
            words_seen = 0;
            foreach (valid[i])
            begin
                valid[i] = 1'b0;
                mask[i] = '0;
                ivl[i] = '0;
                last_time[i] = '0;
                calls[i] = '0;
            end
        endfunction

        function void load_run_bits(logic [psc_pkg::DATA_W-1:0] v);
            run_bits = v;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void push_word(int s, logic f, logic [psc_pkg::SLEEP_W-1:0] sl,
                                logic [psc_pkg::DATA_W-1:0] cc,
                                logic [psc_pkg::DATA_W-1:0] tot, logic lst);
            result_word_t w;
            w.slot_no = s[psc_pkg::SLOT_W-1:0];
            w.fired = f;
            w.sleep_ms = sl;
            w.calls = cc;
            w.total = tot;
            w.last_word = lst;
            due_words.push_back(w);
        endfunction

        function void take_command(logic [psc_pkg::CMD_W-1:0] c,
                                   logic [psc_pkg::SLOT_W-1:0] s,
                                   logic [psc_pkg::DATA_W-1:0] m,
                                   logic [psc_pkg::DATA_W-1:0] iv,
                                   logic [psc_pkg::DATA_W-1:0] nw);
            int n;
            logic [psc_pkg::DATA_W-1:0] gap;
            logic [psc_pkg::DATA_W-1:0] wait_ms;
            logic [psc_pkg::DATA_W-1:0] tot;
            n = 0;
            case (c)
                psc_pkg::CMD_ADD:
                begin
                    if (s < N_SLOTS)
                    begin
                        valid[s] = 1'b1;
                        mask[s] = m;
                        ivl[s] = iv;
                        last_time[s] = '0;
                        calls[s] = '0;
                    end
                end
                psc_pkg::CMD_REMOVE:
                begin
                    if (s < N_SLOTS)
                        valid[s] = 1'b0;
                end
                psc_pkg::CMD_TICK:
                begin
                    if (run_bits != 0)
                    begin
                        for (int i = 0; i < SCAN_N; i++)
                        begin
                            gap = nw - last_time[i];
                            if (valid[i] && (mask[i] & run_bits) != 0 && gap >= ivl[i])
                            begin
                                last_time[i] = nw;
                                calls[i] = calls[i] + 1;
                                push_word(i, 1'b1, '0, calls[i], '0, 1'b0);
                                n++;
                            end
                        end
                    end
                    if (n == 0)
                        push_word(0, 1'b0, '0, '0, '0, 1'b1);
                    else
                        due_words[due_words.size()-1].last_word = 1'b1;
                end
                psc_pkg::CMD_SLEEP:
                begin
                    if (run_bits == 0)
                        push_word(0, 1'b0, '0, '0, '0, 1'b1);
                    else
                    begin
                        wait_ms = psc_pkg::DATA_W'(psc_pkg::SLEEP_CAP);
                        for (int i = 0; i < SCAN_N; i++)
                        begin
                            if (valid[i] && (mask[i] & run_bits) != 0)
                            begin
                                if (ivl[i] == 1)
                                    wait_ms = '0;
                                else
                                begin
                                    gap = last_time[i] + ivl[i] - nw;
                                    if (gap < wait_ms)
                                        wait_ms = gap;
                                end
                            end
                        end
                        if (wait_ms > psc_pkg::DATA_W'(psc_pkg::SLEEP_CAP))
                            wait_ms = psc_pkg::DATA_W'(psc_pkg::SLEEP_CAP);
                        sleep_sum = sleep_sum + wait_ms;
                        push_word(0, 1'b0, wait_ms[psc_pkg::SLEEP_W-1:0], '0, '0, 1'b1);
                    end
                end
                psc_pkg::CMD_STATS:
                begin
                    tot = sleep_sum;
                    for (int i = 0; i < SCAN_N; i++)
                    begin
                        if (valid[i] && calls[i] != 0)
                        begin
                            push_word(i, 1'b0, '0, calls[i], tot, 1'b0);
                            calls[i] = '0;
                            n++;
                        end
                    end
                    sleep_sum = '0;
                    if (n == 0)
                        push_word(0, 1'b0, '0, '0, tot, 1'b1);
                    else
                        due_words[due_words.size()-1].last_word = 1'b1;
                end
                default:
                    ;
            endcase
        endfunction

        task report_mismatch(string what);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task compare_field(string name, logic [psc_pkg::DATA_W-1:0] got,
                           logic [psc_pkg::DATA_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("word %0d %s got %h want %h",
                                          words_seen, name, got, want));
        endtask

        task check_word(result_word_t got);
            result_word_t want;
            if (due_words.size() == 0)
                report_mismatch($sformatf("result word %0d with no word due", words_seen));
            else
            begin
                want = due_words.pop_front();
                compare_field("task_slot", psc_pkg::DATA_W'(got.slot_no),
                              psc_pkg::DATA_W'(want.slot_no));
                compare_field("fired", psc_pkg::DATA_W'(got.fired),
                              psc_pkg::DATA_W'(want.fired));
                compare_field("sleep_ms", psc_pkg::DATA_W'(got.sleep_ms),
                              psc_pkg::DATA_W'(want.sleep_ms));
                compare_field("call_count", got.calls, want.calls);
                compare_field("sleep_total", got.total, want.total);
                compare_field("last", psc_pkg::DATA_W'(got.last_word),
                              psc_pkg::DATA_W'(want.last_word));
            end
            words_seen++;
        endtask
    endclass

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [psc_pkg::CMD_W-1:0]    cmd = '0;
    logic [psc_pkg::SLOT_W-1:0]   slot = '0;
    logic [psc_pkg::DATA_W-1:0]   state_mask = '0;
    logic [psc_pkg::DATA_W-1:0]   interval = '0;
    logic [psc_pkg::DATA_W-1:0]   now = '0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [psc_pkg::DATA_W-1:0]   cfg_data = '0;
    logic                         result_valid;
    logic [psc_pkg::SLOT_W-1:0]   task_slot;
    logic                         fired;
    logic [psc_pkg::SLEEP_W-1:0]  sleep_ms;
    logic [psc_pkg::DATA_W-1:0]   call_count;
    logic [psc_pkg::DATA_W-1:0]   sleep_total;
    logic                         last;

    sched_scoreboard              sb = new();
    int                           cycles = 0;
    int                           idle_pct = 0;
    // millisecond time the stimulus walks forward; ticks and sleeps carry it
    logic [psc_pkg::DATA_W-1:0]   clock_ms = '0;

    periodic_task_scheduler_top #(
        .NUM_SLOTS (N_SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .slot         (slot),
        .state_mask   (state_mask),
        .interval     (interval),
        .now          (now),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .task_slot    (task_slot),
        .fired        (fired),
        .sleep_ms     (sleep_ms),
        .call_count   (call_count),
        .sleep_total  (sleep_total),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop: far above the slowest legal run (every command a full ring
    // rotation, every gap the longest one, plus drains and settle pauses).
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result monitor: the receiver cannot stall, so every strobe is a word.
    // Sampling at the edge reads the values of the cycle that edge ends.
    always @(posedge clk)
    begin
        result_word_t got;
        if (rst_n && result_valid)
        begin
            got.slot_no = task_slot;
            got.fired = fired;
            got.sleep_ms = sleep_ms;
            got.calls = call_count;
            got.total = sleep_total;
            got.last_word = last;
            sb.check_word(got);
        end
    end

    // Present one command and hold it until the block takes it. Start stays
    // high on return so that a following command goes out without a gap.
    task automatic send_word(logic [psc_pkg::CMD_W-1:0] c, logic [psc_pkg::SLOT_W-1:0] s,
                             logic [psc_pkg::DATA_W-1:0] m, logic [psc_pkg::DATA_W-1:0] iv,
                             logic [psc_pkg::DATA_W-1:0] nw);
        start <= 1'b1;
        cmd <= c;
        slot <= s;
        state_mask <= m;
        interval <= iv;
        now <= nw;
        do
            @(posedge clk);
        while (busy);
        sb.take_command(c, s, m, iv, nw);
    endtask

    // Drop start and hold off until every predicted word has come out.
    // Always advance at least one edge so start is never lowered and raised
    // within the same step.
    task automatic drain_words();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Write the run-state register only with the block idle: drained,
    // settled and busy low.
    task automatic write_run_bits(logic [psc_pkg::DATA_W-1:0] v);
        drain_words();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.load_run_bits(v);
    endtask

    function automatic logic [psc_pkg::DATA_W-1:0] pick_mask();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ALL_ONES;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return sb.run_bits | $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [psc_pkg::DATA_W-1:0] pick_interval();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return 32'd1;
            2: return ALL_ONES;
            3: return $urandom;
            4: return $urandom_range(900, 1200);
            default: return $urandom_range(2, 80);
        endcase
    endfunction

    // Move the millisecond clock: mostly small steps so intervals fall due,
    // now and then a jump anywhere or right up to the wrap.
    function automatic logic [psc_pkg::DATA_W-1:0] advance_clock();
        case ($urandom_range(0, 19))
            0: clock_ms = $urandom;
            1: clock_ms = ALL_ONES - $urandom_range(0, 40);
            default: clock_ms = clock_ms + $urandom_range(0, 40);
        endcase
        return clock_ms;
    endfunction

    // One random command; counted is low for the commands the block ignores.
    task automatic send_random_word(output bit counted);
        int pick;
        logic [psc_pkg::CMD_W-1:0] c;
        logic [psc_pkg::DATA_W-1:0] nw;
        pick = $urandom_range(0, 99);
        counted = 1'b1;
        nw = $urandom;
        if (pick < 20)
            c = psc_pkg::CMD_ADD;
        else if (pick < 28)
            c = psc_pkg::CMD_REMOVE;
        else if (pick < 66)
            c = psc_pkg::CMD_TICK;
        else if (pick < 83)
            c = psc_pkg::CMD_SLEEP;
        else if (pick < 94)
            c = psc_pkg::CMD_STATS;
        else
        begin
            c = psc_pkg::CMD_W'($urandom_range(psc_pkg::CMD_STATS + 1, CMD_TOP));
            counted = 1'b0;
        end
        if (c == psc_pkg::CMD_TICK || c == psc_pkg::CMD_SLEEP)
            nw = advance_clock();
        send_word(c, psc_pkg::SLOT_W'($urandom_range(0, N_SLOTS - 1)), pick_mask(),
                  pick_interval(), nw);
    endtask

    initial
    begin
        logic [psc_pkg::DATA_W-1:0] rs_plan[8];
        int idle_plan[4];
        int n;
        bit counted;

        rs_plan = '{ALL_ONES, 32'h0000_0001, 32'h8000_0000, 32'h0,
                    $urandom, 32'h0000_FFFF, $urandom, ALL_ONES};
        // no idling, sender idle about half the time, none again, then light
        idle_plan = '{0, 51, 0, 21};

        // hold reset, then release it once
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: stopped scheduler first (run state is zero out of reset)
        send_word(psc_pkg::CMD_STATS, '0, '0, '0, '0);       // no calls recorded yet
        send_word(psc_pkg::CMD_TICK, '0, '0, '0, 32'd100);   // stopped: nothing fires
        send_word(psc_pkg::CMD_SLEEP, '0, '0, '0, 32'd100);  // stopped: zero wait, no total
        for (int u = psc_pkg::CMD_STATS + 1; u <= CMD_TOP; u++)
            send_word(psc_pkg::CMD_W'(u), 4'hF, ALL_ONES, ALL_ONES, ALL_ONES);
        send_word(psc_pkg::CMD_ADD, 4'd0, ALL_ONES, 32'd1, '0);
        send_word(psc_pkg::CMD_TICK, '0, '0, '0, 32'd5);     // still stopped
        write_run_bits(ALL_ONES);

        // --- directed: table extremes with everything running
        send_word(psc_pkg::CMD_ADD, 4'hF, 32'h8000_0000, ALL_ONES, '0);
        send_word(psc_pkg::CMD_ADD, 4'd3, 32'h0000_0001, '0, '0);    // zero interval
        send_word(psc_pkg::CMD_ADD, 4'd7, '0, 32'd5, '0);            // mask never matches
        send_word(psc_pkg::CMD_ADD, 4'd9, 32'h0000_0100, 32'd5000, '0);
        send_word(psc_pkg::CMD_SLEEP, '0, '0, '0, '0);       // interval-one task forces 0
        send_word(psc_pkg::CMD_TICK, '0, '0, '0, '0);
        send_word(psc_pkg::CMD_TICK, '0, '0, '0, ALL_ONES);  // elapsed time at its largest
        send_word(psc_pkg::CMD_STATS, '0, '0, '0, '0);
        send_word(psc_pkg::CMD_REMOVE, 4'd0, '0, '0, '0);
        send_word(psc_pkg::CMD_SLEEP, '0, '0, '0, 32'd2);    // long wait capped
        send_word(psc_pkg::CMD_REMOVE, 4'd3, '0, '0, '0);
        send_word(psc_pkg::CMD_REMOVE, 4'd15, '0, '0, '0);
        send_word(psc_pkg::CMD_REMOVE, 4'd7, '0, '0, '0);
        send_word(psc_pkg::CMD_REMOVE, 4'd9, '0, '0, '0);
        send_word(psc_pkg::CMD_TICK, '0, '0, '0, 32'd10);    // empty table
        send_word(psc_pkg::CMD_SLEEP, '0, '0, '0, 32'd10);   // empty table: full cap
        send_word(psc_pkg::CMD_STATS, '0, '0, '0, '0);       // sleep total only

        // --- random phases, two run states each; the register is rewritten
        // only after a full drain
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_plan[ph];
            for (int half = 0; half < 2; half++)
            begin
                write_run_bits(rs_plan[2 * ph + half]);
                clock_ms = $urandom;
                n = 0;
                while (n < 48)
                begin
                    send_random_word(counted);
                    if (counted)
                        n++;
                    // sender gaps of varying length land on every cycle of the rotation
                    if ($urandom_range(0, 99) < idle_pct)
                    begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 24)) @(posedge clk);
                    end
                    // occasionally hold off until the block has emptied out
                    if ($urandom_range(0, 99) < 3)
                        drain_words();
                end
            end
        end

        // wait out the last words, then a settle pause
        drain_words();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
